FILE: rtl/circular_deque_defines.svh
// Assertion macros for the deque RTL.
// Included by circular_deque, which carries concurrent checks; expects clk and rst_n in scope.
`ifndef CIRCULAR_DEQUE_DEFINES_SVH
`define CIRCULAR_DEQUE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define CDQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while in reset.
`define CDQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/cdq_pkg.sv
// Shared constants, codes and ring index helpers for the circular deque.
// No dependencies; imported by circular_deque.
package cdq_pkg;

  localparam int DEPTH  = 64;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int SLOT_W = IDX_W + 1;
  localparam int DATA_W = 32;
  localparam int KIND_W = 3;
  localparam int STAT_W = 3;

  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_REAR  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POP_REAR   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DUMP       = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK         = 3'd0;
  localparam logic [STAT_W-1:0] STAT_OVERFLOW   = 3'd1;
  localparam logic [STAT_W-1:0] STAT_UNDERFLOW  = 3'd2;
  localparam logic [STAT_W-1:0] STAT_ELEMENT    = 3'd3;
  localparam logic [STAT_W-1:0] STAT_EMPTY_DUMP = 3'd4;

  localparam logic [SLOT_W-1:0] SLOTS_MIN   = SLOT_W'(2);
  localparam logic [SLOT_W-1:0] SLOTS_MAX   = SLOT_W'(DEPTH);
  localparam logic [SLOT_W-1:0] SLOTS_RESET = SLOT_W'(DEPTH);

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [SLOT_W-1:0] slots_t;

  // Clamp the programmed slot count into the legal ring size.
  function automatic slots_t ring_size(input slots_t s);
    slots_t r;
    if (s < SLOTS_MIN) r = SLOTS_MIN;
    else if (s > SLOTS_MAX) r = SLOTS_MAX;
    else r = s;
    return r;
  endfunction

  function automatic idx_t step_up(input idx_t i, input slots_t n);
    slots_t nx;
    nx = {1'b0, i} + SLOT_W'(1);
    return (nx >= n) ? '0 : nx[IDX_W-1:0];
  endfunction

  function automatic idx_t step_down(input idx_t i, input slots_t n);
    slots_t top;
    top = n - SLOT_W'(1);
    return (i == '0 || {1'b0, i} >= n) ? top[IDX_W-1:0] : i - IDX_W'(1);
  endfunction

endpackage

FILE: rtl/circular_deque.sv
// Circular deque top level: ring index control, dump walker and output register.
// Depends on cdq_pkg, cdq_ram and circular_deque_defines.svh.
`include "circular_deque_defines.svh"

// Double-ended queue over a 64-entry ring store, capacity one less than the
// programmed slot count (clamped to 2..64). Push and pop items, an unknown kind
// and a dump of an empty deque each give one status word (none for an unknown
// kind). A dump of stored values runs the walker through its read and wait states:
// per value it issues one read of the single-port-read store, waits for the
// registered read data and loads the value word once the output is free. Input
// is held off during a dump. Writing the slot count empties the deque; the
// store needs no clearing pass after reset since only pushed slots are read.
module circular_deque
  import cdq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [DATA_W-1:0]    in_tdata,   // [31:0] value_in
  input  logic [KIND_W-1:0]    in_tuser,   // [2:0] kind
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [DATA_W-1:0]    out_tdata,  // [31:0] value_out
  output logic [STAT_W-1:0]    out_tuser,  // [2:0] status
  output logic                 out_tlast,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [SLOT_W-1:0]    cfg_data    // [6:0] slots_in_use
);

  localparam logic [1:0] ST_IDLE      = 2'd0;
  localparam logic [1:0] ST_DUMP_RD   = 2'd1;
  localparam logic [1:0] ST_DUMP_WAIT = 2'd2;

  logic [1:0]        state_r, state_nxt;
  slots_t            slots_r;
  idx_t              head_r, head_nxt;
  idx_t              tail_r, tail_nxt;
  idx_t              ptr_r, ptr_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] out_status_r, out_status_nxt;
  logic [DATA_W-1:0] out_value_r, out_value_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_load;

  slots_t            ring_n;
  logic              empty, full, out_free, in_fire, cfg_fire;
  idx_t              ptr_up;

  logic              mem_we, mem_re;
  idx_t              mem_waddr;
  logic [DATA_W-1:0] mem_rdata;

  cdq_ram #(
    .ADDR_W (IDX_W),
    .DATA_W (DATA_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (in_tdata),
    .re    (mem_re),
    .raddr (ptr_r),
    .rdata (mem_rdata)
  );

  assign ring_n    = ring_size(slots_r);
  assign empty     = (head_r == tail_r);
  assign full      = (step_up(tail_r, ring_n) == head_r);
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && out_free;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign ptr_up    = step_up(ptr_r, ring_n);
  assign mem_re    = (state_r == ST_DUMP_RD);

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    ptr_nxt        = ptr_r;
    out_load       = 1'b0;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_last_nxt   = out_last_r;
    mem_we         = 1'b0;
    mem_waddr      = tail_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          out_value_nxt = '0;
          out_last_nxt  = 1'b1;
          unique case (in_tuser)
            KIND_PUSH_FRONT: begin
              out_load = 1'b1;
              if (full) begin
                out_status_nxt = STAT_OVERFLOW;
              end else begin
                head_nxt       = step_down(head_r, ring_n);
                mem_we         = 1'b1;
                mem_waddr      = head_nxt;
                out_status_nxt = STAT_OK;
              end
            end
            KIND_PUSH_REAR: begin
              out_load = 1'b1;
              if (full) begin
                out_status_nxt = STAT_OVERFLOW;
              end else begin
                mem_we         = 1'b1;
                mem_waddr      = tail_r;
                tail_nxt       = step_up(tail_r, ring_n);
                out_status_nxt = STAT_OK;
              end
            end
            KIND_POP_FRONT: begin
              out_load = 1'b1;
              if (empty) begin
                out_status_nxt = STAT_UNDERFLOW;
              end else begin
                head_nxt       = step_up(head_r, ring_n);
                out_status_nxt = STAT_OK;
              end
            end
            KIND_POP_REAR: begin
              out_load = 1'b1;
              if (empty) begin
                out_status_nxt = STAT_UNDERFLOW;
              end else begin
                tail_nxt       = step_down(tail_r, ring_n);
                out_status_nxt = STAT_OK;
              end
            end
            KIND_DUMP: begin
              if (empty) begin
                out_load       = 1'b1;
                out_status_nxt = STAT_EMPTY_DUMP;
              end else begin
                ptr_nxt   = head_r;
                state_nxt = ST_DUMP_RD;
              end
            end
            default: begin
              // drop unknown kinds without a result
            end
          endcase
        end
      end
      ST_DUMP_RD: begin
        state_nxt = ST_DUMP_WAIT;
      end
      ST_DUMP_WAIT: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_status_nxt = STAT_ELEMENT;
          out_value_nxt  = mem_rdata;
          out_last_nxt   = (ptr_up == tail_r);
          ptr_nxt        = ptr_up;
          state_nxt      = (ptr_up == tail_r) ? ST_IDLE : ST_DUMP_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      slots_r     <= SLOTS_RESET;
      head_r      <= '0;
      tail_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_fire) begin
        // new ring size empties the deque
        slots_r <= cfg_data;
        head_r  <= '0;
        tail_r  <= '0;
      end else begin
        head_r <= head_nxt;
        tail_r <= tail_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr_r        <= ptr_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

  `CDQ_ASSERT_NOW(a_head_in_ring, 1'b1, ({1'b0, head_r} < ring_n), "head index outside ring")
  `CDQ_ASSERT_NOW(a_tail_in_ring, 1'b1, ({1'b0, tail_r} < ring_n), "tail index outside ring")
  `CDQ_ASSERT_NOW(a_no_accept_in_dump, state_r != ST_IDLE, !in_tready, "input taken during dump")
  `CDQ_ASSERT_NEXT(a_read_then_wait, state_r == ST_DUMP_RD, state_r == ST_DUMP_WAIT,
                   "dump read not followed by wait")
  `CDQ_ASSERT_NOW(a_mid_dump_word,
                  out_valid_r && out_status_r == STAT_ELEMENT && !out_last_r,
                  state_r != ST_IDLE, "dump ended before last word")

endmodule

FILE: rtl/cdq_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; used by circular_deque as the ring store.
module cdq_ram #(
  parameter int ADDR_W = 6,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Hold the last read word until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
